FILE: src/clp_pkg.sv
package clp_pkg;

	localparam int        MARKER_LEN = 5;
	localparam logic [7:0] NEWLINE   = 8'h0A;

	// overflow marker "<F>\n" plus terminating zero
	localparam logic [7:0] MARKER_BYTES [0:MARKER_LEN-1] = '{8'h3C, 8'h46, 8'h3E, 8'h0A, 8'h00};

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_IRQ   = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_code;
		logic       send_ok;
		logic       one_slot_left;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [4:0] packet_length;
		logic       last_of_packet;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_APPEND,
		ST_CHECK,
		ST_MARK_BASE,
		ST_MARK_WR,
		ST_SEND_INIT,
		ST_SEND_EMPTY,
		ST_SEND_RD,
		ST_SEND_WR
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic append;
		logic set_pending;
		logic mark_base;
		logic mark_write;
		logic send_init;
		logic rd;
		logic load_byte;
		logic load_empty;
		logic send_done;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] mode;
		logic       ok;
		logic       one_slot;
		logic       char_nl;
		logic       pending;
		logic       full;
		logic       fill_zero;
		logic       mark_last;
		logic       send_last;
		logic       out_free;
	} dp_sts_t;

endpackage

FILE: src/clp_dpath.sv
module clp_dpath #(
	parameter int PACKET_BYTES = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clp_pkg::in_word_t  req,
	input  clp_pkg::dp_cmd_t   cmd,
	output clp_pkg::dp_sts_t   sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output clp_pkg::out_word_t rsp
);

	localparam int FW = $clog2(PACKET_BYTES + 1);
	localparam int AW = $clog2(PACKET_BYTES);
	localparam int KW = $clog2(clp_pkg::MARKER_LEN);

	// latched item
	logic [1:0] mode_q;
	logic [7:0] char_q;
	logic       ok_q;
	logic       slot_q;

	logic [FW-1:0] fill_q;
	logic          pending_q;
	logic          last_nl_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] base_q;
	logic [KW-1:0] k_q;

	logic [7:0] mem [0:PACKET_BYTES-1];
	logic [7:0] rdata_q;

	logic                rsp_valid_q;
	clp_pkg::out_word_t  rsp_q;

	logic          full;
	logic          out_free;
	logic [FW:0]   start_w;
	logic [FW:0]   end_w;
	logic [AW-1:0] base_w;
	logic [FW:0]   mark_fill_w;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	assign full     = (fill_q >= FW'(PACKET_BYTES));
	assign out_free = !rsp_valid_q || !rsp_stall;

	// marker placement: back over a trailing newline, clamp to buffer end
	always_comb begin
		start_w = {1'b0, fill_q} - (FW+1)'(((fill_q != '0) && last_nl_q) ? 1 : 0);
		end_w   = start_w + (FW+1)'(clp_pkg::MARKER_LEN);
		if (end_w >= (FW+1)'(PACKET_BYTES)) begin
			base_w = AW'(PACKET_BYTES - clp_pkg::MARKER_LEN);
		end else begin
			base_w = start_w[AW-1:0];
		end
		mark_fill_w = (FW+1)'(base_q) + (FW+1)'(clp_pkg::MARKER_LEN);
	end

	// single write port
	always_comb begin
		we    = 1'b0;
		waddr = fill_q[AW-1:0];
		wdata = char_q;
		if (cmd.mark_write) begin
			we    = 1'b1;
			waddr = base_q + AW'(k_q);
			wdata = clp_pkg::MARKER_BYTES[k_q];
		end else if (cmd.append && !full) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= req.mode;
			char_q <= req.char_code;
			ok_q   <= req.send_ok;
			slot_q <= req.one_slot_left;
		end
		if (cmd.mark_base) begin
			base_q <= base_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pending_q <= 1'b0;
			last_nl_q <= 1'b0;
			idx_q     <= '0;
			k_q       <= '0;
		end else begin
			if (cmd.append && !full) begin
				fill_q    <= fill_q + FW'(1);
				last_nl_q <= (char_q == clp_pkg::NEWLINE);
			end
			if (cmd.set_pending) begin
				pending_q <= 1'b1;
			end
			if (cmd.mark_base) begin
				k_q <= '0;
			end
			if (cmd.mark_write) begin
				k_q <= k_q + KW'(1);
				if (k_q == KW'(clp_pkg::MARKER_LEN - 1)) begin
					fill_q    <= mark_fill_w[FW-1:0];
					last_nl_q <= 1'b0;
				end
			end
			if (cmd.send_init) begin
				idx_q <= '0;
			end
			if (cmd.load_byte) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.send_done) begin
				fill_q    <= '0;
				pending_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_byte || cmd.load_empty) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			rsp_q.data_byte      <= rdata_q;
			rsp_q.packet_length  <= 5'(fill_q);
			rsp_q.last_of_packet <= sts.send_last;
		end else if (cmd.load_empty) begin
			rsp_q.data_byte      <= '0;
			rsp_q.packet_length  <= '0;
			rsp_q.last_of_packet <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts.mode      = mode_q;
		sts.ok        = ok_q;
		sts.one_slot  = slot_q;
		sts.char_nl   = (char_q == clp_pkg::NEWLINE);
		sts.pending   = pending_q;
		sts.full      = full;
		sts.fill_zero = (fill_q == '0);
		sts.mark_last = (k_q == KW'(clp_pkg::MARKER_LEN - 1));
		sts.send_last = ((FW'(idx_q) + FW'(1)) == fill_q);
		sts.out_free  = out_free;
	end

endmodule

FILE: src/clp_ctrl.sv
module clp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  clp_pkg::dp_sts_t sts,
	output clp_pkg::dp_cmd_t cmd
);

	clp_pkg::ctl_state_t state_q, state_d;
	logic retry_q, retry_d;   // send in progress is the retry of a pending packet

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clp_pkg::ST_IDLE;
			retry_q <= 1'b0;
		end else begin
			state_q <= state_d;
			retry_q <= retry_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		retry_d   = retry_q;
		cmd       = '0;
		req_stall = (state_q != clp_pkg::ST_IDLE);
		unique case (state_q)
			clp_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = clp_pkg::ST_DECODE;
				end
			end
			clp_pkg::ST_DECODE: begin
				retry_d = 1'b0;
				unique case (sts.mode)
					clp_pkg::MODE_PUT: begin
						if (sts.pending && sts.ok) begin
							retry_d = 1'b1;
							state_d = clp_pkg::ST_SEND_INIT;
						end else if (sts.pending) begin
							state_d = clp_pkg::ST_IDLE;
						end else begin
							state_d = clp_pkg::ST_APPEND;
						end
					end
					clp_pkg::MODE_IRQ: state_d = clp_pkg::ST_APPEND;
					clp_pkg::MODE_FLUSH: begin
						state_d = sts.ok ? clp_pkg::ST_SEND_INIT : clp_pkg::ST_IDLE;
					end
					default: state_d = clp_pkg::ST_IDLE;
				endcase
			end
			clp_pkg::ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = (sts.mode == clp_pkg::MODE_PUT) ? clp_pkg::ST_CHECK
				                                             : clp_pkg::ST_IDLE;
			end
			clp_pkg::ST_CHECK: begin
				if (sts.char_nl || sts.full) begin
					cmd.set_pending = 1'b1;
					if (sts.one_slot) begin
						state_d = clp_pkg::ST_MARK_BASE;
					end else begin
						state_d = sts.ok ? clp_pkg::ST_SEND_INIT : clp_pkg::ST_IDLE;
					end
				end else begin
					state_d = clp_pkg::ST_IDLE;
				end
			end
			clp_pkg::ST_MARK_BASE: begin
				cmd.mark_base = 1'b1;
				state_d       = clp_pkg::ST_MARK_WR;
			end
			clp_pkg::ST_MARK_WR: begin
				cmd.mark_write = 1'b1;
				if (sts.mark_last) begin
					state_d = sts.ok ? clp_pkg::ST_SEND_INIT : clp_pkg::ST_IDLE;
				end
			end
			clp_pkg::ST_SEND_INIT: begin
				cmd.send_init = 1'b1;
				state_d = sts.fill_zero ? clp_pkg::ST_SEND_EMPTY : clp_pkg::ST_SEND_RD;
			end
			clp_pkg::ST_SEND_EMPTY: begin
				if (sts.out_free) begin
					cmd.load_empty = 1'b1;
					cmd.send_done  = 1'b1;
					state_d = retry_q ? clp_pkg::ST_APPEND : clp_pkg::ST_IDLE;
					retry_d = 1'b0;
				end
			end
			clp_pkg::ST_SEND_RD: begin
				cmd.rd  = 1'b1;
				state_d = clp_pkg::ST_SEND_WR;
			end
			clp_pkg::ST_SEND_WR: begin
				if (sts.out_free) begin
					cmd.load_byte = 1'b1;
					if (sts.send_last) begin
						cmd.send_done = 1'b1;
						state_d = retry_q ? clp_pkg::ST_APPEND : clp_pkg::ST_IDLE;
						retry_d = 1'b0;
					end else begin
						state_d = clp_pkg::ST_SEND_RD;
					end
				end
			end
			default: state_d = clp_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: src/console_line_packetizer_top.sv
// channel | dir | word        | handshake
// req     | in  | in_word_t   | req_valid / req_stall, taken when valid & !stall
// rsp     | out | out_word_t  | rsp_valid / rsp_stall, taken when valid & !stall
//
// One input word at a time, accept to next accept. Each byte of a packet that is sent
// is read from the line buffer, then loaded into the output register; an empty packet
// is loaded straight into the output register, and the overflow marker, when needed,
// is written into the buffer before the send.
// Reset clears fill count, pending flag and control; buffer contents are not cleared.
// A stalled rsp holds the controller in its send state; req stays stalled until done.
module console_line_packetizer_top #(
	parameter int PACKET_BYTES = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  clp_pkg::in_word_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output clp_pkg::out_word_t rsp
);

	// command and status between controller and datapath
	clp_pkg::dp_cmd_t cmd;
	clp_pkg::dp_sts_t sts;

	// controller: sequences retry, append, marker write and packet send
	clp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: line buffer, fill count, pending flag, output register
	clp_dpath #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int PACKET_BYTES = 30;
	localparam int MARK_LEN     = 5;
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for the pressure test
	localparam int SETTLE       = 200;   // > worst word latency (two full packets)

	// unused mode value, must be ignored by the block
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [7:0] LF = 8'h0A;
	// overflow marker: '<' 'F' '>' '\n' 0
	localparam logic [7:0] OVF_MARK [MARK_LEN] = '{8'h3C, 8'h46, 8'h3E, 8'h0A, 8'h00};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	clp_pkg::in_word_t  req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	clp_pkg::out_word_t rsp;

	console_line_packetizer_top #(
		.PACKET_BYTES(PACKET_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Line packetizer prediction: own copy of the buffer, count and flag.
	// Every byte of an accepted packet is pushed into packet_bytes_q.
	// ------------------------------------------------------------------
	logic [7:0]         line_mem [PACKET_BYTES];
	int unsigned        fill = 0;
	bit                 retry_wait = 1'b0;
	clp_pkg::out_word_t packet_bytes_q [$];

	bit idle_on   = 1'b1;   // random gaps on both sides
	bit hold_rsp  = 1'b0;   // request for one long receiver hold-off
	int words_in  = 0;
	int bytes_out = 0;
	int packets   = 0;
	int mismatches = 0;

	// send attempt: on success the whole buffer goes out and is cleared
	task automatic ship_buffer(bit ok);
		clp_pkg::out_word_t b;
		if (ok) begin
			if (fill == 0) begin
				b.data_byte      = 8'h00;
				b.packet_length  = 5'd0;
				b.last_of_packet = 1'b1;
				packet_bytes_q.push_back(b);
			end else begin
				for (int i = 0; i < fill; i++) begin
					b.data_byte      = line_mem[i];
					b.packet_length  = fill[4:0];
					b.last_of_packet = (i + 1 == fill);
					packet_bytes_q.push_back(b);
				end
			end
			fill       = 0;
			retry_wait = 1'b0;
		end
	endtask

	task automatic append_byte(logic [7:0] c);
		if (fill < PACKET_BYTES) begin
			line_mem[fill] = c;
			fill++;
		end
	endtask

	// marker after the text (back over a trailing newline) or over the tail
	task automatic place_marker();
		int unsigned first;
		int unsigned stop;
		first = fill;
		if (first > 0 && line_mem[first - 1] == LF)
			first--;
		stop = first + MARK_LEN;
		if (stop >= PACKET_BYTES)
			stop = PACKET_BYTES;
		for (int i = 0; i < MARK_LEN; i++)
			line_mem[stop - MARK_LEN + i] = OVF_MARK[i];
		fill = stop;
	endtask

	task automatic packetize(clp_pkg::in_word_t w);
		case (w.mode)
			clp_pkg::MODE_PUT: begin
				if (retry_wait)
					ship_buffer(w.send_ok);
				if (!retry_wait) begin
					append_byte(w.char_code);
					if (w.char_code == LF || fill >= PACKET_BYTES) begin
						if (w.one_slot_left)
							place_marker();
						retry_wait = 1'b1;
						ship_buffer(w.send_ok);
					end
				end
			end
			clp_pkg::MODE_IRQ: begin
				append_byte(w.char_code);
			end
			clp_pkg::MODE_FLUSH: begin
				ship_buffer(w.send_ok);
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender: called right after a rising edge. Optional gap, then the
	// word is offered and held until the block takes it. Valid stays high
	// into the next word when there is no gap.
	// ------------------------------------------------------------------
	task automatic send_word(logic [1:0] m, logic [7:0] c, bit ok, bit slot);
		clp_pkg::in_word_t w;
		int                gap;
		w.mode          = m;
		w.char_code     = c;
		w.send_ok       = ok;
		w.one_slot_left = slot;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		packetize(w);
		words_in++;
	endtask

	// ------------------------------------------------------------------
	// Receiver back-pressure: one stall value per stretch, so rsp_stall
	// gets a single assignment per edge.
	// ------------------------------------------------------------------
	initial begin
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Byte checker: every taken output word against the oldest expected.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		clp_pkg::out_word_t exp_b;
		if (arst_n && rsp_valid && !rsp_stall) begin
			bytes_out++;
			if (rsp.last_of_packet)
				packets++;
			if (packet_bytes_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: byte %h len %0d last %b",
						rsp.data_byte, rsp.packet_length, rsp.last_of_packet);
			end else begin
				exp_b = packet_bytes_q.pop_front();
				if (rsp.data_byte !== exp_b.data_byte ||
				    rsp.packet_length !== exp_b.packet_length ||
				    rsp.last_of_packet !== exp_b.last_of_packet) begin
					mismatches++;
					if (mismatches <= 10)
						$display("bad output: exp byte %h len %0d last %b, %s",
							exp_b.data_byte, exp_b.packet_length,
							exp_b.last_of_packet,
							$sformatf("got byte %h len %0d last %b",
								rsp.data_byte, rsp.packet_length,
								rsp.last_of_packet));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// byte extremes, every mode, refused send and retry, marker placement
	task automatic test_directed_modes();
		send_word(clp_pkg::MODE_PUT,   8'h41, 1'b1, 1'b0);
		send_word(clp_pkg::MODE_PUT,   8'h00, 1'b1, 1'b0);
		send_word(clp_pkg::MODE_PUT,   8'hFF, 1'b1, 1'b0);
		send_word(clp_pkg::MODE_PUT,   LF,    1'b1, 1'b0);   // 4-byte packet
		send_word(clp_pkg::MODE_FLUSH, 8'hFF, 1'b1, 1'b1);   // empty packet
		send_word(clp_pkg::MODE_FLUSH, 8'h00, 1'b0, 1'b0);   // refused, nothing out
		send_word(MODE_NONE,           8'hFF, 1'b1, 1'b1);   // ignored
		send_word(clp_pkg::MODE_IRQ,   8'h55, 1'b1, 1'b0);
		send_word(clp_pkg::MODE_IRQ,   8'hAA, 1'b0, 1'b1);
		send_word(clp_pkg::MODE_PUT,   LF,    1'b0, 1'b0);   // refused -> stays pending
		send_word(clp_pkg::MODE_PUT,   8'h78, 1'b0, 1'b0);   // retry refused, char dropped
		send_word(clp_pkg::MODE_IRQ,   8'h79, 1'b0, 1'b0);   // irq still appends
		send_word(clp_pkg::MODE_PUT,   8'h7A, 1'b1, 1'b0);   // retry goes, then char kept
		send_word(clp_pkg::MODE_PUT,   LF,    1'b1, 1'b1);   // marker rewinds over newline
		send_word(clp_pkg::MODE_PUT,   8'h71, 1'b1, 1'b1);
		send_word(clp_pkg::MODE_PUT,   8'h72, 1'b1, 1'b1);
		send_word(clp_pkg::MODE_PUT,   LF,    1'b0, 1'b1);   // marker, refused
		send_word(clp_pkg::MODE_FLUSH, 8'h00, 1'b1, 1'b0);   // flush clears pending
		send_word(clp_pkg::MODE_PUT,   LF,    1'b1, 1'b0);   // lone newline
		send_word(clp_pkg::MODE_PUT,   LF,    1'b1, 1'b1);   // marker from position 0
	endtask

	// fill to the limit, drop on full, marker over the tail
	task automatic test_full_buffer();
		for (int i = 0; i < PACKET_BYTES; i++)
			send_word(clp_pkg::MODE_IRQ, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'b0);
		send_word(clp_pkg::MODE_IRQ, 8'hEE, 1'b1, 1'b0);   // dropped
		send_word(clp_pkg::MODE_PUT, 8'h6B, 1'b0, 1'b1);   // dropped, refused, tail marker
		send_word(clp_pkg::MODE_PUT, 8'h6D, 1'b1, 1'b0);   // retry 30 bytes, then append
		send_word(clp_pkg::MODE_PUT, LF,    1'b1, 1'b0);
	endtask

	// mostly well-formed lines with random content, some noise
	task automatic test_random_lines(int target);
		int         done;
		int         len;
		logic [1:0] m;
		done = 0;
		while (done < target) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 34)
			                                  : $urandom_range(0, 10);
			for (int k = 0; k < len; k++) begin
				m = ($urandom_range(0, 6) == 0) ? clp_pkg::MODE_IRQ : clp_pkg::MODE_PUT;
				send_word(m, 8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
					$urandom_range(0, 4) == 0);
				done++;
			end
			case ($urandom_range(0, 9))
				0: begin
					send_word(clp_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)),
						$urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
					done++;
				end
				1: send_word(MODE_NONE, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: begin
					send_word(clp_pkg::MODE_PUT, LF, $urandom_range(0, 4) != 0,
						$urandom_range(0, 3) == 0);
					done++;
				end
			endcase
		end
	endtask

	// receiver holds off while lines keep coming; block must stall its input
	task automatic test_output_hold();
		hold_rsp = 1'b1;
		for (int n = 0; n < 3; n++) begin
			for (int k = 0; k < 8; k++)
				send_word(clp_pkg::MODE_PUT, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
			send_word(clp_pkg::MODE_PUT, LF, 1'b1, n == 1);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_modes();
		test_full_buffer();
		test_output_hold();
		test_random_lines(55);

		// closing stretch with no gaps or stalls
		idle_on = 1'b0;
		test_random_lines(15);
		req_valid <= 1'b0;

		wait (packet_bytes_q.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("run: %0d input words, %0d output bytes in %0d packets",
			words_in, bytes_out, packets);
		$display("run: refused sends and retries, flushes, full lines, %s",
			"overflow markers, long output hold");
		if (mismatches == 0 && packet_bytes_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#(10_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
src/clp_pkg.sv
src/clp_dpath.sv
src/clp_ctrl.sv
src/console_line_packetizer_top.sv
test/tb_top.sv
